/* rtl/tgarle_pkg.sv */
// ----------------------------------------------------------------------------
// TGA run-length decoder package
// Shared result type, status codes and header layout constants.
// ----------------------------------------------------------------------------
package tgarle_pkg;

   // Result status codes.
   localparam logic [2:0] ST_HDR_OK    = 3'd0;
   localparam logic [2:0] ST_PIXEL     = 3'd1;
   localparam logic [2:0] ST_DONE      = 3'd2;
   localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
   localparam logic [2:0] ST_ZERO_SIZE = 3'd4;
   localparam logic [2:0] ST_BAD_DEPTH = 3'd5;
   localparam logic [2:0] ST_TRUNC     = 3'd6;

   // Header byte positions.
   localparam logic [4:0] HDR_IDENT_LEN = 5'd0;
   localparam logic [4:0] HDR_KIND      = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;
   localparam logic [4:0] HDR_LAST      = 5'd17;

   // Image type codes.
   localparam logic [7:0] KIND_RAW_COLOR = 8'd2;
   localparam logic [7:0] KIND_RAW_GRAY  = 8'd3;
   localparam logic [7:0] KIND_RLE_COLOR = 8'd10;
   localparam logic [7:0] KIND_RLE_GRAY  = 8'd11;

   // One result as it sits in the output queue.
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] pixel_value;
      logic [7:0]  repeat_count;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [2:0]  pixel_bytes;
      logic        last_of_input;
   } rsp_type;

   // Builds a result with the last flag cleared.
   function automatic rsp_type make_rsp(input logic [2:0]  status,
                                        input logic [31:0] pixel,
                                        input logic [7:0]  count,
                                        input logic [15:0] width,
                                        input logic [15:0] height,
                                        input logic [2:0]  depth);
      rsp_type r;
      r.status        = status;
      r.pixel_value   = pixel;
      r.repeat_count  = count;
      r.image_width   = width;
      r.image_height  = height;
      r.pixel_bytes   = depth;
      r.last_of_input = 1'b0;
      return r;
   endfunction

endpackage

/* rtl/tga_rle_image_decoder_core.sv */
// Results are registered into the output queue and driven on the rsp_ ports from its head.
// Throughput: one byte per cycle; a byte may yield two results, drained through a
// four-entry output queue that holds req_ready low while fewer than two slots are free.
// Reset (synchronous, active high) returns the parser to the header and empties the queue.
// ----------------------------------------------------------------------------
// TGA run-length decoder core
// Parses the TGA header, skips the ident field and decodes raw and run-length
// pixel packets into pixel/repeat-count results, one file byte per request.
// ----------------------------------------------------------------------------
module tga_rle_image_decoder_core
   import tgarle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_pixel_value,
   output logic [7:0]  rsp_repeat_count,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [2:0]  rsp_pixel_bytes,
   output logic        rsp_last_of_input
);

   // Parser phases.
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_IDENT  = 3'd1;
   localparam logic [2:0] PH_PACKET = 3'd2;
   localparam logic [2:0] PH_PIXEL  = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;
   localparam logic [2:0] PH_SKIP   = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  hdr_count_ff, hdr_count_in;
   logic [7:0]  ident_ff, ident_in;
   logic [7:0]  kind_ff, kind_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [2:0]  bpp_ff, bpp_in;
   logic [31:0] pix_rem_ff, pix_rem_in;
   logic [7:0]  pkt_rem_ff, pkt_rem_in;
   logic        pkt_run_ff, pkt_run_in;
   logic [31:0] assembly_ff, assembly_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;

   // Output queue.
   rsp_type     queue_ff [4];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;

   logic        accept;
   logic        pop;
   logic        is_rle;
   logic        go_data;
   logic [4:0]  depth_code;
   logic [31:0] merged;
   logic [7:0]  run_cnt;
   logic [31:0] pix_after;
   logic [1:0]  n_res;
   rsp_type     res_a;
   rsp_type     res_b;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (count_ff <= 3'd2);
   assign is_rle    = (kind_ff == KIND_RLE_COLOR) || (kind_ff == KIND_RLE_GRAY);
   assign depth_code = req_data_byte[7:3];

   // Current pixel with the incoming byte placed at its lane.
   always_comb begin
      merged = assembly_ff;
      case (byte_idx_ff)
         2'd0:    merged[7:0]   = req_data_byte;
         2'd1:    merged[15:8]  = req_data_byte;
         2'd2:    merged[23:16] = req_data_byte;
         default: merged[31:24] = req_data_byte;
      endcase
   end

   // Repeat count of this pixel, clipped to the pixels left in the image.
   always_comb begin
      run_cnt = (is_rle && pkt_run_ff) ? pkt_rem_ff : 8'd1;
      if ({24'd0, run_cnt} > pix_rem_ff) begin
         run_cnt = pix_rem_ff[7:0];
      end
      pix_after = pix_rem_ff - {24'd0, run_cnt};
   end

   // Parser next state and the results of the accepted byte.
   always_comb begin
      phase_in     = phase_ff;
      hdr_count_in = hdr_count_ff;
      ident_in     = ident_ff;
      kind_in      = kind_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      bpp_in       = bpp_ff;
      pix_rem_in   = pix_rem_ff;
      pkt_rem_in   = pkt_rem_ff;
      pkt_run_in   = pkt_run_ff;
      assembly_in  = assembly_ff;
      byte_idx_in  = byte_idx_ff;
      go_data      = 1'b0;
      n_res        = 2'd0;
      res_a        = '0;
      res_b        = '0;

      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               case (hdr_count_ff)
                  HDR_IDENT_LEN: ident_in = req_data_byte;
                  HDR_KIND:      kind_in = req_data_byte;
                  HDR_WIDTH_LO:  width_in[7:0] = req_data_byte;
                  HDR_WIDTH_HI:  width_in[15:8] = req_data_byte;
                  HDR_HEIGHT_LO: height_in[7:0] = req_data_byte;
                  HDR_HEIGHT_HI: height_in[15:8] = req_data_byte;
                  HDR_DEPTH: begin
                     if (depth_code == 5'd1 || depth_code == 5'd3 || depth_code == 5'd4) begin
                        bpp_in = depth_code[2:0];
                     end else begin
                        bpp_in = 3'd0;
                     end
                  end
                  default: ;
               endcase
               if (hdr_count_ff < HDR_LAST) begin
                  hdr_count_in = hdr_count_ff + 5'd1;
               end else begin
                  hdr_count_in = 5'd0;
                  n_res        = 2'd1;
                  if (!(kind_ff == KIND_RAW_COLOR || kind_ff == KIND_RAW_GRAY || is_rle)) begin
                     res_a    = make_rsp(ST_BAD_TYPE, '0, '0, '0, '0, '0);
                     phase_in = PH_SKIP;
                  end else if (width_ff == 16'd0 || height_ff == 16'd0) begin
                     res_a    = make_rsp(ST_ZERO_SIZE, '0, '0, '0, '0, '0);
                     phase_in = PH_SKIP;
                  end else if (bpp_ff == 3'd0) begin
                     res_a    = make_rsp(ST_BAD_DEPTH, '0, '0, '0, '0, '0);
                     phase_in = PH_SKIP;
                  end else begin
                     res_a      = make_rsp(ST_HDR_OK, '0, '0, width_ff, height_ff, bpp_ff);
                     pix_rem_in = 32'(width_ff) * 32'(height_ff);
                     if (ident_ff != 8'd0) begin
                        phase_in = PH_IDENT;
                     end else begin
                        go_data = 1'b1;
                     end
                  end
               end
            end
            PH_IDENT: begin
               if (ident_ff > 8'd0) begin
                  ident_in = ident_ff - 8'd1;
               end
               if (ident_in == 8'd0) begin
                  go_data = 1'b1;
               end
            end
            PH_PACKET: begin
               pkt_run_in  = req_data_byte[7];
               pkt_rem_in  = req_data_byte[7] ? (req_data_byte - 8'd127)
                                              : (req_data_byte + 8'd1);
               assembly_in = '0;
               byte_idx_in = 2'd0;
               phase_in    = PH_PIXEL;
            end
            PH_PIXEL: begin
               if ({1'b0, byte_idx_ff} + 3'd1 < bpp_ff) begin
                  assembly_in = merged;
                  byte_idx_in = byte_idx_ff + 2'd1;
               end else begin
                  n_res       = 2'd1;
                  res_a       = make_rsp(ST_PIXEL, merged, run_cnt, '0, '0, '0);
                  pix_rem_in  = pix_after;
                  assembly_in = '0;
                  byte_idx_in = 2'd0;
                  if (pix_after == 32'd0) begin
                     n_res    = 2'd2;
                     res_b    = make_rsp(ST_DONE, '0, '0, '0, '0, '0);
                     phase_in = PH_DONE;
                  end else if (is_rle) begin
                     if (pkt_run_ff) begin
                        phase_in = PH_PACKET;
                     end else begin
                        if (pkt_rem_ff > 8'd0) begin
                           pkt_rem_in = pkt_rem_ff - 8'd1;
                        end
                        if (pkt_rem_in == 8'd0) begin
                           phase_in = PH_PACKET;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase

         // Start of pixel data after the header or ident field.
         if (go_data) begin
            assembly_in = '0;
            byte_idx_in = 2'd0;
            pkt_run_in  = 1'b0;
            pkt_rem_in  = 8'd0;
            phase_in    = is_rle ? PH_PACKET : PH_PIXEL;
         end

         // End of stream: report truncation if data was still owed, then restart.
         if (req_stream_end) begin
            if (phase_in == PH_HEADER || phase_in == PH_IDENT ||
                phase_in == PH_PACKET || phase_in == PH_PIXEL) begin
               if (n_res == 2'd0) begin
                  res_a = make_rsp(ST_TRUNC, '0, '0, '0, '0, '0);
               end else begin
                  res_b = make_rsp(ST_TRUNC, '0, '0, '0, '0, '0);
               end
               n_res = n_res + 2'd1;
            end
            phase_in     = PH_HEADER;
            hdr_count_in = '0;
            ident_in     = '0;
            kind_in      = '0;
            width_in     = '0;
            height_in    = '0;
            bpp_in       = '0;
            pix_rem_in   = '0;
            pkt_rem_in   = '0;
            pkt_run_in   = 1'b0;
            assembly_in  = '0;
            byte_idx_in  = '0;
         end

         // Flag the final result of this request.
         if (n_res == 2'd1) begin
            res_a.last_of_input = 1'b1;
         end else if (n_res == 2'd2) begin
            res_b.last_of_input = 1'b1;
         end
      end
   end

   // Queue pointer bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_res;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {1'b0, n_res} - {2'b0, pop};
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_count_ff <= '0;
         ident_ff     <= '0;
         kind_ff      <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         bpp_ff       <= '0;
         pix_rem_ff   <= '0;
         pkt_rem_ff   <= '0;
         pkt_run_ff   <= 1'b0;
         assembly_ff  <= '0;
         byte_idx_ff  <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         hdr_count_ff <= hdr_count_in;
         ident_ff     <= ident_in;
         kind_ff      <= kind_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         bpp_ff       <= bpp_in;
         pix_rem_ff   <= pix_rem_in;
         pkt_rem_ff   <= pkt_rem_in;
         pkt_run_ff   <= pkt_run_in;
         assembly_ff  <= assembly_in;
         byte_idx_ff  <= byte_idx_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

   // Queue storage: up to two results written per cycle.
   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res_a;
      end
      if (n_res == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= res_b;
      end
   end

   // Head of the queue drives the response channel.
   assign rsp_valid         = (count_ff != 3'd0);
   assign rsp_status        = queue_ff[rd_ptr_ff].status;
   assign rsp_pixel_value   = queue_ff[rd_ptr_ff].pixel_value;
   assign rsp_repeat_count  = queue_ff[rd_ptr_ff].repeat_count;
   assign rsp_image_width   = queue_ff[rd_ptr_ff].image_width;
   assign rsp_image_height  = queue_ff[rd_ptr_ff].image_height;
   assign rsp_pixel_bytes   = queue_ff[rd_ptr_ff].pixel_bytes;
   assign rsp_last_of_input = queue_ff[rd_ptr_ff].last_of_input;

endmodule

/* rtl/tgarle_checker.sv */
// ----------------------------------------------------------------------------
// TGA run-length decoder port checker
// Watches the response channel of the core for consistency over time.
// ----------------------------------------------------------------------------
module tgarle_checker
   import tgarle_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_pixel_value,
   input logic [7:0]  rsp_repeat_count,
   input logic [15:0] rsp_image_width,
   input logic [15:0] rsp_image_height,
   input logic [2:0]  rsp_pixel_bytes,
   input logic        rsp_last_of_input
);

   // A stalled response holds its status and pixel.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_pixel_value))
      else $error("response changed while stalled");

   // A pixel result always carries at least one copy.
   a_pixel_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_PIXEL |-> rsp_repeat_count != 8'd0)
      else $error("pixel result with zero repeat count");

   // Header fields appear only with a good header.
   a_hdr_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_HDR_OK |->
         rsp_image_width == 16'd0 && rsp_image_height == 16'd0 &&
         rsp_pixel_bytes == 3'd0)
      else $error("header fields on a non-header result");

   // Image done is always the final result of its byte.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DONE |-> rsp_last_of_input)
      else $error("image done not marked last");

endmodule

bind tga_rle_image_decoder_core tgarle_checker u_tgarle_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_pixel_value   (rsp_pixel_value),
   .rsp_repeat_count  (rsp_repeat_count),
   .rsp_image_width   (rsp_image_width),
   .rsp_image_height  (rsp_image_height),
   .rsp_pixel_bytes   (rsp_pixel_bytes),
   .rsp_last_of_input (rsp_last_of_input)
);
